[rtl/core/rsub_pkg.sv]
// Package for the rectangle subtract block: side codes, the piece plan
// struct and default widths. Depends on nothing; every other file imports it.
package rsub_pkg;

    // Default coordinate width of all rectangle corners.
    localparam int unsigned COORD_WIDTH_DEF = 16;

    // Width of the side code and number of possible pieces per item.
    localparam int unsigned SIDE_W    = 3;
    localparam int unsigned NUM_SLOTS = 5;

    // Side code of an emitted piece; the value doubles as its slot index.
    typedef enum logic [SIDE_W-1:0] {
        SIDE_WHOLE = 3'd0,
        SIDE_UP    = 3'd1,
        SIDE_LEFT  = 3'd2,
        SIDE_RIGHT = 3'd3,
        SIDE_DOWN  = 3'd4
    } t_side;

    // Which pieces one item produces.
    typedef struct packed {
        logic pass;   // no overlap: base goes out unchanged
        logic up;
        logic left;
        logic right;
        logic down;
    } t_plan;

endpackage

[rtl/core/rsub_in_if.sv]
// Input channel of the rectangle subtract block: base and cut rectangles.
// Depends on rsub_pkg for the default coordinate width.
interface rsub_in_if
    import rsub_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] base_sx;
    logic signed [COORD_WIDTH-1:0] base_ex;
    logic signed [COORD_WIDTH-1:0] base_sy;
    logic signed [COORD_WIDTH-1:0] base_ey;
    logic signed [COORD_WIDTH-1:0] cut_sx;
    logic signed [COORD_WIDTH-1:0] cut_ex;
    logic signed [COORD_WIDTH-1:0] cut_sy;
    logic signed [COORD_WIDTH-1:0] cut_ey;

    modport source (
        output valid, base_sx, base_ex, base_sy, base_ey,
               cut_sx, cut_ex, cut_sy, cut_ey,
        input  ready
    );

    modport sink (
        input  valid, base_sx, base_ex, base_sy, base_ey,
               cut_sx, cut_ex, cut_sy, cut_ey,
        output ready
    );
endinterface

[rtl/core/rsub_out_if.sv]
// Output channel of the rectangle subtract block: one remaining piece per transfer.
// Depends on rsub_pkg for the default coordinate width and side code width.
interface rsub_out_if
    import rsub_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] piece_sx;
    logic signed [COORD_WIDTH-1:0] piece_ex;
    logic signed [COORD_WIDTH-1:0] piece_sy;
    logic signed [COORD_WIDTH-1:0] piece_ey;
    logic        [SIDE_W-1:0]      piece_side;
    logic                          piece_last;

    modport source (
        output valid, piece_sx, piece_ex, piece_sy, piece_ey, piece_side, piece_last,
        input  ready
    );

    modport sink (
        input  valid, piece_sx, piece_ex, piece_sy, piece_ey, piece_side, piece_last,
        output ready
    );
endinterface

[rtl/core/rsub_calc.sv]
// Geometry of the rectangle subtract block: overlap test, piece plan and the
// corners of the piece on the selected side. Pure combinational; uses rsub_pkg.
module rsub_calc
    import rsub_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic signed [COORD_WIDTH-1:0] i_base_sx,
    input  logic signed [COORD_WIDTH-1:0] i_base_ex,
    input  logic signed [COORD_WIDTH-1:0] i_base_sy,
    input  logic signed [COORD_WIDTH-1:0] i_base_ey,
    input  logic signed [COORD_WIDTH-1:0] i_cut_sx,
    input  logic signed [COORD_WIDTH-1:0] i_cut_ex,
    input  logic signed [COORD_WIDTH-1:0] i_cut_sy,
    input  logic signed [COORD_WIDTH-1:0] i_cut_ey,
    input  t_side                         i_side,
    output t_plan                         o_plan,
    output logic signed [COORD_WIDTH-1:0] o_sx,
    output logic signed [COORD_WIDTH-1:0] o_ex,
    output logic signed [COORD_WIDTH-1:0] o_sy,
    output logic signed [COORD_WIDTH-1:0] o_ey
);
    localparam int unsigned EW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [EW-1:0] bsx_e, bex_e, bsy_e, bey_e;
    logic signed [EW-1:0] csx_m1, cex_p1, csy_m1, cey_p1;
    logic signed [EW-1:0] mid_sy, mid_ey;
    logic                 ovl;

    // Overlap test on the cut as given.
    assign lo_x = (i_base_ex < i_cut_ex) ? i_base_ex : i_cut_ex;
    assign hi_x = (i_base_sx > i_cut_sx) ? i_base_sx : i_cut_sx;
    assign lo_y = (i_base_ey < i_cut_ey) ? i_base_ey : i_cut_ey;
    assign hi_y = (i_base_sy > i_cut_sy) ? i_base_sy : i_cut_sy;
    assign ovl  = (lo_x >= hi_x) && (lo_y >= hi_y);

    // Grown cut, one bit wider so that it never wraps.
    assign bsx_e  = EW'(i_base_sx);
    assign bex_e  = EW'(i_base_ex);
    assign bsy_e  = EW'(i_base_sy);
    assign bey_e  = EW'(i_base_ey);
    assign csx_m1 = EW'(i_cut_sx) - EW'(signed'(1));
    assign cex_p1 = EW'(i_cut_ex) + EW'(signed'(1));
    assign csy_m1 = EW'(i_cut_sy) - EW'(signed'(1));
    assign cey_p1 = EW'(i_cut_ey) + EW'(signed'(1));

    // Rows shared by the left and right pieces.
    assign mid_sy = (bsy_e > csy_m1) ? bsy_e : csy_m1;
    assign mid_ey = (bey_e < cey_p1) ? bey_e : cey_p1;

    // Which sides leave a remainder.
    assign o_plan.pass  = !ovl;
    assign o_plan.up    = bsy_e <= csy_m1;
    assign o_plan.left  = bsx_e <= csx_m1;
    assign o_plan.right = bex_e >= cex_p1;
    assign o_plan.down  = bey_e >= cey_p1;

    // Corners of the selected piece; every emitted value lies inside the base.
    always_comb begin
        o_sx = i_base_sx;
        o_ex = i_base_ex;
        o_sy = i_base_sy;
        o_ey = i_base_ey;
        unique case (i_side)
            SIDE_WHOLE: begin
            end
            SIDE_UP: begin
                o_ey = csy_m1[COORD_WIDTH-1:0];
            end
            SIDE_LEFT: begin
                o_ex = csx_m1[COORD_WIDTH-1:0];
                o_sy = mid_sy[COORD_WIDTH-1:0];
                o_ey = mid_ey[COORD_WIDTH-1:0];
            end
            SIDE_RIGHT: begin
                o_sx = cex_p1[COORD_WIDTH-1:0];
                o_sy = mid_sy[COORD_WIDTH-1:0];
                o_ey = mid_ey[COORD_WIDTH-1:0];
            end
            SIDE_DOWN: begin
                o_sy = cey_p1[COORD_WIDTH-1:0];
            end
            default: begin
            end
        endcase
    end
endmodule

[rtl/core/rectangle_subtract.sv]
// Rectangle subtract: input register, piece sequencer and output register.
// Depends on rsub_pkg, rsub_in_if, rsub_out_if and rsub_calc.
// The first piece goes through the input register and then the output register.
// Throughput: one piece per cycle via the single output register while not stalled;
// an item has up to four pieces, and the next item is taken as its last one issues.
// Reset clears the input and output valid flags and the emitted-piece mask.
module rectangle_subtract
    import rsub_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsub_in_if.sink     i_req,
    rsub_out_if.source  o_piece
);
    // Input register.
    logic                          r_in_valid, n_in_valid;
    logic signed [COORD_WIDTH-1:0] r_base_sx, r_base_ex, r_base_sy, r_base_ey;
    logic signed [COORD_WIDTH-1:0] r_cut_sx, r_cut_ex, r_cut_sy, r_cut_ey;
    logic [NUM_SLOTS-1:0]          r_done, n_done;

    // Output register.
    logic                          r_out_valid, n_out_valid;
    logic signed [COORD_WIDTH-1:0] r_out_sx, r_out_ex, r_out_sy, r_out_ey;
    t_side                         r_out_side;
    logic                          r_out_last;

    t_plan                         plan;
    t_side                         sel_side;
    logic [NUM_SLOTS-1:0]          want, pend, sel_oh;
    logic signed [COORD_WIDTH-1:0] calc_sx, calc_ex, calc_sy, calc_ey;
    logic                          single, slot_free, issue, item_done, accept;

    rsub_calc #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_calc (
        .i_base_sx (r_base_sx),
        .i_base_ex (r_base_ex),
        .i_base_sy (r_base_sy),
        .i_base_ey (r_base_ey),
        .i_cut_sx  (r_cut_sx),
        .i_cut_ex  (r_cut_ex),
        .i_cut_sy  (r_cut_sy),
        .i_cut_ey  (r_cut_ey),
        .i_side    (sel_side),
        .o_plan    (plan),
        .o_sx      (calc_sx),
        .o_ex      (calc_ex),
        .o_sy      (calc_sy),
        .o_ey      (calc_ey)
    );

    // Pieces of the held item, indexed by side code, and those still to go.
    assign want = plan.pass ? NUM_SLOTS'(1) << SIDE_WHOLE
                            : {plan.down, plan.right, plan.left, plan.up, 1'b0};
    assign pend   = want & ~r_done;
    assign sel_oh = pend & (~pend + NUM_SLOTS'(1));
    assign single = (pend != '0) && ((pend & (pend - NUM_SLOTS'(1))) == '0);

    // Pieces go out in the order whole, up, left, right, down.
    always_comb begin
        priority if (pend[SIDE_WHOLE]) begin
            sel_side = SIDE_WHOLE;
        end else if (pend[SIDE_UP]) begin
            sel_side = SIDE_UP;
        end else if (pend[SIDE_LEFT]) begin
            sel_side = SIDE_LEFT;
        end else if (pend[SIDE_RIGHT]) begin
            sel_side = SIDE_RIGHT;
        end else begin
            sel_side = SIDE_DOWN;
        end
    end

    // Handshake control: the held item retires with its final piece, or at
    // once when it leaves nothing.
    assign slot_free   = !r_out_valid || o_piece.ready;
    assign issue       = r_in_valid && (pend != '0) && slot_free;
    assign item_done   = r_in_valid && ((pend == '0) || (issue && single));
    assign i_req.ready = !r_in_valid || item_done;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        n_done     = r_done;
        if (accept) begin
            n_in_valid = 1'b1;
            n_done     = '0;
        end else if (item_done) begin
            n_in_valid = 1'b0;
        end else if (issue) begin
            n_done = r_done | sel_oh;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (issue) begin
            n_out_valid = 1'b1;
        end else if (o_piece.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    // Input payload register, loaded on each input transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_base_sx <= i_req.base_sx;
            r_base_ex <= i_req.base_ex;
            r_base_sy <= i_req.base_sy;
            r_base_ey <= i_req.base_ey;
            r_cut_sx  <= i_req.cut_sx;
            r_cut_ex  <= i_req.cut_ex;
            r_cut_sy  <= i_req.cut_sy;
            r_cut_ey  <= i_req.cut_ey;
        end
    end

    // Output payload register, loaded when a piece is issued.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out_sx   <= calc_sx;
            r_out_ex   <= calc_ex;
            r_out_sy   <= calc_sy;
            r_out_ey   <= calc_ey;
            r_out_side <= sel_side;
            r_out_last <= single;
        end
    end

    assign o_piece.valid      = r_out_valid;
    assign o_piece.piece_sx   = r_out_sx;
    assign o_piece.piece_ex   = r_out_ex;
    assign o_piece.piece_sy   = r_out_sy;
    assign o_piece.piece_ey   = r_out_ey;
    assign o_piece.piece_side = r_out_side;
    assign o_piece.piece_last = r_out_last;

    // An issued piece is always presented on the next cycle.
    a_issue_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> r_out_valid)
        else $error("issued piece not presented");

    // Only pieces the item actually has are ever marked as sent.
    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> ((r_done & ~want) == '0))
        else $error("sent mask holds a piece outside the plan");

    // A pass-through item sends the whole base as its only piece.
    a_pass_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && plan.pass) |-> (sel_side == SIDE_WHOLE && single))
        else $error("pass-through item not sent as one whole piece");

    // Marking a piece as last retires the held item in the same cycle.
    a_last_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && single) |-> item_done)
        else $error("last piece sent without retiring the item");
endmodule

[bench/rectangle_subtract_tb.sv]
`timescale 1ns / 100ps
// Testbench for rectangle_subtract: drives base/cut rectangle pairs, predicts the
// remaining pieces of each pair and checks every piece transfer in order.
// Depends on rsub_pkg, rsub_in_if, rsub_out_if and the rectangle_subtract RTL.
module rectangle_subtract_tb;
    import rsub_pkg::*;

    localparam int unsigned CW      = COORD_WIDTH_DEF;
    localparam int          C_MIN   = -(1 <<< (CW - 1));
    localparam int          C_MAX   = (1 <<< (CW - 1)) - 1;
    localparam int          END_WAIT = 5000;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord base_sx;
        t_coord base_ex;
        t_coord base_sy;
        t_coord base_ey;
        t_coord cut_sx;
        t_coord cut_ex;
        t_coord cut_sy;
        t_coord cut_ey;
    } t_rect_pair;

    typedef struct packed {
        t_coord sx;
        t_coord ex;
        t_coord sy;
        t_coord ey;
        t_side  side;
        logic   last;
    } t_piece;

    logic i_clk;
    logic i_rst_n;

    rsub_in_if  #(.COORD_WIDTH(CW)) req_if ();
    rsub_out_if #(.COORD_WIDTH(CW)) piece_if ();

    rectangle_subtract #(
        .COORD_WIDTH(CW)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_piece (piece_if.source)
    );

    // Pieces still owed by the block, oldest first.
    t_piece      pending_pieces[$];
    t_piece      next_piece;
    int unsigned error_count;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;

    // Free-running clock, 2 ns period.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Known values on every input from time zero.
    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.base_sx = '0;
        req_if.base_ex = '0;
        req_if.base_sy = '0;
        req_if.base_ey = '0;
        req_if.cut_sx  = '0;
        req_if.cut_ex  = '0;
        req_if.cut_sy  = '0;
        req_if.cut_ey  = '0;
        piece_if.ready = 1'b0;
        error_count    = 0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        piece_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Computes the pieces that one rectangle pair leaves behind and queues them.
    function automatic void predict_pieces(input t_rect_pair r);
        longint bsx, bex, bsy, bey, csx, cex, csy, cey, row_lo, row_hi;
        t_piece found[4];
        int     n;
        bsx = longint'(r.base_sx);
        bex = longint'(r.base_ex);
        bsy = longint'(r.base_sy);
        bey = longint'(r.base_ey);
        csx = longint'(r.cut_sx);
        cex = longint'(r.cut_ex);
        csy = longint'(r.cut_sy);
        cey = longint'(r.cut_ey);
        n   = 0;

        // An empty overlap in either axis passes the base through as given.
        if ((bex < cex ? bex : cex) < (bsx > csx ? bsx : csx) ||
            (bey < cey ? bey : cey) < (bsy > csy ? bsy : csy)) begin
            pending_pieces.push_back({r.base_sx, r.base_ex, r.base_sy, r.base_ey,
                                      SIDE_WHOLE, 1'b1});
            return;
        end

        // Grow the cut by one pixel per side, at full precision.
        csx = csx - 1;
        cex = cex + 1;
        csy = csy - 1;
        cey = cey + 1;
        row_lo = (bsy > csy) ? bsy : csy;
        row_hi = (bey < cey) ? bey : cey;

        if (bsy <= csy) begin
            found[n] = {r.base_sx, r.base_ex, r.base_sy, t_coord'(csy), SIDE_UP, 1'b0};
            n++;
        end
        if (bsx <= csx) begin
            found[n] = {r.base_sx, t_coord'(csx), t_coord'(row_lo), t_coord'(row_hi),
                        SIDE_LEFT, 1'b0};
            n++;
        end
        if (bex >= cex) begin
            found[n] = {t_coord'(cex), r.base_ex, t_coord'(row_lo), t_coord'(row_hi),
                        SIDE_RIGHT, 1'b0};
            n++;
        end
        if (bey >= cey) begin
            found[n] = {r.base_sx, r.base_ex, t_coord'(cey), r.base_ey, SIDE_DOWN, 1'b0};
            n++;
        end

        for (int k = 0; k < n; k++) begin
            found[k].last = (k == n - 1);
            pending_pieces.push_back(found[k]);
        end
    endfunction

    // Checks each piece transfer against the oldest outstanding piece.
    always @(posedge i_clk) begin
        if (i_rst_n && piece_if.valid === 1'b1 && piece_if.ready === 1'b1) begin
            if (pending_pieces.size() == 0) begin
                $error("unexpected piece: side %0d sx %0d ex %0d sy %0d ey %0d",
                       piece_if.piece_side, piece_if.piece_sx, piece_if.piece_ex,
                       piece_if.piece_sy, piece_if.piece_ey);
                error_count++;
            end else begin
                next_piece = pending_pieces.pop_front();
                if (piece_if.piece_sx !== next_piece.sx) begin
                    $error("piece_sx: expected %0d, got %0d", next_piece.sx,
                           piece_if.piece_sx);
                    error_count++;
                end
                if (piece_if.piece_ex !== next_piece.ex) begin
                    $error("piece_ex: expected %0d, got %0d", next_piece.ex,
                           piece_if.piece_ex);
                    error_count++;
                end
                if (piece_if.piece_sy !== next_piece.sy) begin
                    $error("piece_sy: expected %0d, got %0d", next_piece.sy,
                           piece_if.piece_sy);
                    error_count++;
                end
                if (piece_if.piece_ey !== next_piece.ey) begin
                    $error("piece_ey: expected %0d, got %0d", next_piece.ey,
                           piece_if.piece_ey);
                    error_count++;
                end
                if (piece_if.piece_side !== next_piece.side) begin
                    $error("piece_side: expected %0d, got %0d", next_piece.side,
                           piece_if.piece_side);
                    error_count++;
                end
                if (piece_if.piece_last !== next_piece.last) begin
                    $error("piece_last: expected %0d, got %0d", next_piece.last,
                           piece_if.piece_last);
                    error_count++;
                end
            end
        end
    end

    function automatic int clip_coord(input int v);
        return (v < C_MIN) ? C_MIN : ((v > C_MAX) ? C_MAX : v);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(2 ** CW - 1)) + C_MIN;
    endfunction

    function automatic t_rect_pair make_pair(input int bsx, input int bex, input int bsy,
                                             input int bey, input int csx, input int cex,
                                             input int csy, input int cey);
        return {t_coord'(bsx), t_coord'(bex), t_coord'(bsy), t_coord'(bey),
                t_coord'(csx), t_coord'(cex), t_coord'(csy), t_coord'(cey)};
    endfunction

    // Picks a coordinate from near the range ends, near zero, or anywhere.
    function automatic int edge_coord();
        case ($urandom_range(7))
            0: return C_MIN;
            1: return C_MIN + 1;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return C_MAX - 1;
            6: return C_MAX;
            default: return rand_coord();
        endcase
    endfunction

    // Random rectangle pair: mostly small overlapping rectangles anywhere in the
    // range, plus raw noise, pairs at the range corners and near-covering cuts.
    function automatic t_rect_pair rand_pair();
        int kind, bsx, bex, bsy, bey, csx, cex, csy, cey, t;
        kind = int'($urandom_range(99));
        if (kind < 60) begin
            bsx = rand_coord();
            bsy = rand_coord();
            bex = clip_coord(bsx + int'($urandom_range(40)));
            bey = clip_coord(bsy + int'($urandom_range(40)));
            csx = clip_coord(bsx + int'($urandom_range(75)) - 30);
            csy = clip_coord(bsy + int'($urandom_range(75)) - 30);
            cex = clip_coord(csx + int'($urandom_range(40)));
            cey = clip_coord(csy + int'($urandom_range(40)));
        end else if (kind < 75) begin
            bsx = rand_coord();
            bex = rand_coord();
            bsy = rand_coord();
            bey = rand_coord();
            csx = rand_coord();
            cex = rand_coord();
            csy = rand_coord();
            cey = rand_coord();
        end else if (kind < 90) begin
            bsx = edge_coord();
            bex = edge_coord();
            bsy = edge_coord();
            bey = edge_coord();
            csx = edge_coord();
            cex = edge_coord();
            csy = edge_coord();
            cey = edge_coord();
            // Keep most of these well ordered so that they can overlap.
            if ($urandom_range(99) < 80) begin
                if (bsx > bex) begin t = bsx; bsx = bex; bex = t; end
                if (bsy > bey) begin t = bsy; bsy = bey; bey = t; end
                if (csx > cex) begin t = csx; csx = cex; cex = t; end
                if (csy > cey) begin t = csy; csy = cey; cey = t; end
            end
        end else begin
            bsx = rand_coord();
            bsy = rand_coord();
            bex = clip_coord(bsx + int'($urandom_range(20)));
            bey = clip_coord(bsy + int'($urandom_range(20)));
            csx = clip_coord(bsx - int'($urandom_range(3)) + 1);
            csy = clip_coord(bsy - int'($urandom_range(3)) + 1);
            cex = clip_coord(bex + int'($urandom_range(3)) - 1);
            cey = clip_coord(bey + int'($urandom_range(3)) - 1);
        end
        return make_pair(bsx, bex, bsy, bey, csx, cex, csy, cey);
    endfunction

    // Presents one pair, with random idle cycles first, and waits for its transfer.
    task automatic send_pair(input t_rect_pair r);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.base_sx <= r.base_sx;
        req_if.base_ex <= r.base_ex;
        req_if.base_sy <= r.base_sy;
        req_if.base_ey <= r.base_ey;
        req_if.cut_sx  <= r.cut_sx;
        req_if.cut_ex  <= r.cut_ex;
        req_if.cut_sy  <= r.cut_sy;
        req_if.cut_ey  <= r.cut_ey;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        predict_pieces(r);
    endtask

    // Stops sending until every outstanding piece has been received.
    task automatic drain_pieces();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_pieces.size() != 0) @(posedge i_clk);
    endtask

    // Pairs that do not overlap, including inverted rectangles.
    task automatic test_pass_through();
        send_pair(make_pair(0, 10, 0, 10, 20, 30, 0, 10));
        send_pair(make_pair(0, 10, 0, 10, 0, 10, 11, 20));
        send_pair(make_pair(10, 0, 0, 10, 0, 10, 0, 10));
        send_pair(make_pair(0, 10, 0, 10, 5, 5, 8, 2));
        send_pair(make_pair(0, 10, 9, 3, 0, 10, 0, 10));
        drain_pieces();
    endtask

    // Each side on its own, all four together, and cuts at the base border.
    task automatic test_side_pieces();
        send_pair(make_pair(0, 20, 0, 20, 8, 12, 8, 12));
        send_pair(make_pair(0, 10, 0, 10, -5, 15, 5, 15));
        send_pair(make_pair(0, 10, 0, 10, 5, 15, -5, 15));
        send_pair(make_pair(0, 10, 0, 10, -5, 5, -5, 15));
        send_pair(make_pair(0, 10, 0, 10, -5, 15, -5, 5));
        send_pair(make_pair(0, 10, 0, 10, 3, 7, 0, 4));
        send_pair(make_pair(0, 10, 0, 10, 3, 7, 1, 4));
        send_pair(make_pair(0, 10, 0, 10, 10, 20, 10, 20));
        drain_pieces();
    endtask

    // Cuts that cover the whole base leave nothing; a cut one pixel inside leaves a border.
    task automatic test_cut_covers_base();
        send_pair(make_pair(0, 10, 0, 10, 0, 10, 0, 10));
        send_pair(make_pair(0, 10, 0, 10, -3, 14, -2, 12));
        send_pair(make_pair(5, 5, 5, 5, 5, 5, 5, 5));
        send_pair(make_pair(0, 10, 0, 10, 1, 9, 1, 9));
        drain_pieces();
    endtask

    // Coordinates at the ends of the range, where the grown cut leaves it.
    task automatic test_range_extremes();
        send_pair(make_pair(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN));
        send_pair(make_pair(C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        send_pair(make_pair(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX));
        send_pair(make_pair(C_MIN, C_MAX, C_MIN, C_MAX, -1, 0, -1, 0));
        send_pair(make_pair(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN));
        drain_pieces();
    endtask

    // One phase of random pairs under the given sender and receiver idling.
    task automatic test_random(input int count, input int unsigned idle_pct,
                               input int unsigned stall_pct);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        repeat (count) send_pair(rand_pair());
        drain_pieces();
    endtask

    // Test sequence and final verdict.
    initial begin
        int waited;
        waited = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 10;
        snk_stall_pct = 10;
        test_pass_through();
        test_side_pieces();
        test_cut_covers_base();
        test_range_extremes();

        test_random(40, 0, 0);
        test_random(35, 70, 0);
        test_random(40, 0, 70);
        test_random(33, 10, 10);

        // Let any trailing pieces arrive, then check that none are still owed.
        while (pending_pieces.size() != 0 && waited < END_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_pieces.size() != 0) begin
            $error("%0d expected pieces never arrived", pending_pieces.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("rectangle_subtract verification clean");
        end else begin
            $display("rectangle_subtract verification failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #500000;
        $display("rectangle_subtract verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/rsub_pkg.sv
rtl/core/rsub_in_if.sv
rtl/core/rsub_out_if.sv
rtl/core/rsub_calc.sv
rtl/core/rectangle_subtract.sv
bench/rectangle_subtract_tb.sv
